/* sv/plim_pkg.sv */
// shared types and codes for the priority inheritance lock
// used by plim_ctrl, plim_dpath, priority_inheritance_lock and tb_top; no dependencies
package plim_pkg;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 4;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 3;

  localparam logic [KIND_W-1:0] KIND_LOCK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_QUEUED   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REFUSED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

/* sv/priority_inheritance_lock.sv */
// top level of the priority inheritance lock with a priority-ordered wait queue
// depends on plim_pkg, plim_ctrl and plim_dpath
//
//   channel   handshake            payload
//   request   start && !busy       in_kind, in_task_id, in_task_priority
//   result    out_valid (1 cycle)  out_status, out_woken_*, out_owner_*, out_restored_*
//
// each request is latched in the idle state, then the exec state updates the lock state and
// the shift-register wait queue, which inserts or pops by shifting its entries
// the result strobe shows in the cycle after that, when busy is already low again
// synchronous active-low reset frees the lock and empties the queue
// the receiver cannot stall; results are never held back
module priority_inheritance_lock #(
  parameter int MAX_TASKS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [plim_pkg::KIND_W-1:0]    in_kind,
  input  logic [plim_pkg::ID_W-1:0]      in_task_id,
  input  logic [plim_pkg::PRIO_W-1:0]    in_task_priority,
  output logic                           out_valid,
  output logic [plim_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_woken_valid,
  output logic [plim_pkg::ID_W-1:0]      out_woken_task,
  output logic                           out_owner_valid,
  output logic [plim_pkg::ID_W-1:0]      out_owner_task,
  output logic [plim_pkg::PRIO_W-1:0]    out_owner_priority,
  output logic                           out_restored_valid,
  output logic [plim_pkg::PRIO_W-1:0]    out_restored_priority
);
  import plim_pkg::*;

  dp_cmd_t cmd;

  plim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  plim_dpath #(
    .MAX_TASKS     (MAX_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_kind               (in_kind),
    .in_task_id            (in_task_id),
    .in_task_priority      (in_task_priority),
    .out_status            (out_status),
    .out_woken_valid       (out_woken_valid),
    .out_woken_task        (out_woken_task),
    .out_owner_valid       (out_owner_valid),
    .out_owner_task        (out_owner_task),
    .out_owner_priority    (out_owner_priority),
    .out_restored_valid    (out_restored_valid),
    .out_restored_priority (out_restored_priority)
  );

endmodule

/* sv/plim_ctrl.sv */
// controller for the priority inheritance lock: request handshake and result strobe
// depends on plim_pkg
module plim_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output plim_pkg::dp_cmd_t cmd
);
  import plim_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    busy     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/plim_dpath.sv */
// datapath for the priority inheritance lock: owner state, sorted wait queue, result registers
// depends on plim_pkg
module plim_dpath #(
  parameter int MAX_TASKS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  plim_pkg::dp_cmd_t              cmd,
  input  logic [plim_pkg::KIND_W-1:0]    in_kind,
  input  logic [plim_pkg::ID_W-1:0]      in_task_id,
  input  logic [plim_pkg::PRIO_W-1:0]    in_task_priority,
  output logic [plim_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_woken_valid,
  output logic [plim_pkg::ID_W-1:0]      out_woken_task,
  output logic                           out_owner_valid,
  output logic [plim_pkg::ID_W-1:0]      out_owner_task,
  output logic [plim_pkg::PRIO_W-1:0]    out_owner_priority,
  output logic                           out_restored_valid,
  output logic [plim_pkg::PRIO_W-1:0]    out_restored_priority
);
  import plim_pkg::*;

  localparam int PW = PRIORITY_BITS;
  localparam int CW = $clog2(MAX_TASKS + 1);

  // latched request
  logic [KIND_W-1:0] req_kind_r;
  logic [ID_W-1:0]   req_id_r;
  logic [PW-1:0]     req_prio_r;

  // lock state
  logic          held_r, held_nxt;
  logic [ID_W-1:0] holder_r, holder_nxt;
  logic [PW-1:0] hprio_r, hprio_nxt;
  logic [PW-1:0] saved_r, saved_nxt;
  logic          boosted_r, boosted_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // wait queue, sorted by priority, head at index 0
  logic [ID_W-1:0] wid_r   [MAX_TASKS];
  logic [PW-1:0]   wprio_r [MAX_TASKS];
  logic [MAX_TASKS-1:0] take;

  logic                ins_en, pop_en;
  logic [STATUS_W-1:0] status;
  logic                woken_valid, restored_valid;
  logic [ID_W-1:0]     woken_task;
  logic [PW-1:0]       restored_prio;
  logic                full;

  // slot k is at or behind the insert point
  always_comb begin
    for (int k = 0; k < MAX_TASKS; k++) begin
      take[k] = (CW'(k) >= count_r) || (wprio_r[k] > req_prio_r);
    end
  end

  assign full = (count_r == CW'(MAX_TASKS));

  always_comb begin
    held_nxt       = held_r;
    holder_nxt     = holder_r;
    hprio_nxt      = hprio_r;
    saved_nxt      = saved_r;
    boosted_nxt    = boosted_r;
    count_nxt      = count_r;
    ins_en         = 1'b0;
    pop_en         = 1'b0;
    status         = STAT_IGNORED;
    woken_valid    = 1'b0;
    woken_task     = '0;
    restored_valid = 1'b0;
    restored_prio  = '0;
    if (req_kind_r == KIND_LOCK || req_kind_r == KIND_TRY) begin
      priority if (!held_r) begin
        held_nxt   = 1'b1;
        holder_nxt = req_id_r;
        hprio_nxt  = req_prio_r;
        status     = STAT_GRANTED;
      end else if (req_kind_r == KIND_TRY || full) begin
        status = STAT_REFUSED;
      end else begin
        if (req_prio_r < hprio_r) begin
          // original priority is saved on the first boost only
          if (!boosted_r) begin
            saved_nxt   = hprio_r;
            boosted_nxt = 1'b1;
          end
          hprio_nxt = req_prio_r;
        end
        ins_en    = 1'b1;
        count_nxt = count_r + CW'(1);
        status    = STAT_QUEUED;
      end
    end else if (req_kind_r == KIND_UNLOCK) begin
      if (held_r && holder_r == req_id_r) begin
        if (count_r != '0) begin
          pop_en      = 1'b1;
          woken_valid = 1'b1;
          woken_task  = wid_r[0];
          count_nxt   = count_r - CW'(1);
        end
        if (boosted_r) begin
          restored_valid = 1'b1;
          restored_prio  = saved_r;
          hprio_nxt      = saved_r;
          boosted_nxt    = 1'b0;
        end
        held_nxt = 1'b0;
        status   = STAT_RELEASED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r <= in_kind;
      req_id_r   <= in_task_id;
      req_prio_r <= PW'(in_task_priority);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 1'b0;
      holder_r  <= '0;
      hprio_r   <= '0;
      saved_r   <= '0;
      boosted_r <= 1'b0;
      count_r   <= '0;
    end else if (cmd.exec) begin
      held_r    <= held_nxt;
      holder_r  <= holder_nxt;
      hprio_r   <= hprio_nxt;
      saved_r   <= saved_nxt;
      boosted_r <= boosted_nxt;
      count_r   <= count_nxt;
    end
  end

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_slot
    logic first;
    if (k == 0) begin : g_head
      assign first = 1'b1;
    end else begin : g_body
      assign first = !take[k-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec && ins_en && take[k]) begin
        if (first) begin
          wid_r[k]   <= req_id_r;
          wprio_r[k] <= req_prio_r;
        end else begin
          wid_r[k]   <= wid_r[(k == 0) ? 0 : k-1];
          wprio_r[k] <= wprio_r[(k == 0) ? 0 : k-1];
        end
      end else if (cmd.exec && pop_en && k < MAX_TASKS - 1) begin
        wid_r[k]   <= wid_r[(k < MAX_TASKS - 1) ? k+1 : k];
        wprio_r[k] <= wprio_r[(k < MAX_TASKS - 1) ? k+1 : k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status            <= status;
      out_woken_valid       <= woken_valid;
      out_woken_task        <= woken_task;
      out_owner_valid       <= held_nxt;
      out_owner_task        <= held_nxt ? holder_nxt : '0;
      out_owner_priority    <= held_nxt ? PRIO_W'(hprio_nxt) : '0;
      out_restored_valid    <= restored_valid;
      out_restored_priority <= PRIO_W'(restored_prio);
    end
  end

endmodule

/* tb/tb_top.sv */
// self-checking testbench for priority_inheritance_lock: directed and random lock requests
// holds its own lock and wait-queue prediction; depends on plim_pkg and the block's rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plim_pkg::*;

  localparam int MAX_WAITERS  = 16;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                woken_valid;
    logic [ID_W-1:0]     woken_task;
    logic                owner_valid;
    logic [ID_W-1:0]     owner_task;
    logic [PRIO_W-1:0]   owner_priority;
    logic                restored_valid;
    logic [PRIO_W-1:0]   restored_priority;
  } lock_result_t;

  class lock_scoreboard;
    bit                held;
    bit [ID_W-1:0]     holder;
    bit [PRIO_W-1:0]   holder_prio;
    bit [PRIO_W-1:0]   saved_prio;
    bit                boosted;
    bit [ID_W-1:0]     wait_id [MAX_WAITERS];
    bit [PRIO_W-1:0]   wait_prio [MAX_WAITERS];
    int                wait_count;
    lock_result_t      expected_results [$];
    int                errors;

    function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      lock_result_t r;
      int pos;
      r = '0;
      r.status = STAT_IGNORED;
      if (kind == KIND_LOCK || kind == KIND_TRY) begin
        if (!held) begin
          held = 1'b1;
          holder = id;
          holder_prio = prio;
          r.status = STAT_GRANTED;
        end else if (kind == KIND_TRY || wait_count >= MAX_WAITERS) begin
          r.status = STAT_REFUSED;
        end else begin
          // owner inherits a more urgent waiter's priority, original saved once
          if (prio < holder_prio) begin
            if (!boosted) begin
              saved_prio = holder_prio;
              boosted = 1'b1;
            end
            holder_prio = prio;
          end
          pos = 0;
          while (pos < wait_count && wait_prio[pos] <= prio) pos++;
          for (int k = wait_count; k > pos; k--) begin
            wait_id[k] = wait_id[k-1];
            wait_prio[k] = wait_prio[k-1];
          end
          wait_id[pos] = id;
          wait_prio[pos] = prio;
          wait_count++;
          r.status = STAT_QUEUED;
        end
      end else if (kind == KIND_UNLOCK) begin
        if (held && holder == id) begin
          if (wait_count > 0) begin
            r.woken_valid = 1'b1;
            r.woken_task = wait_id[0];
            for (int k = 1; k < wait_count; k++) begin
              wait_id[k-1] = wait_id[k];
              wait_prio[k-1] = wait_prio[k];
            end
            wait_count--;
          end
          if (boosted) begin
            r.restored_valid = 1'b1;
            r.restored_priority = saved_prio;
            holder_prio = saved_prio;
            boosted = 1'b0;
          end
          held = 1'b0;
          r.status = STAT_RELEASED;
        end
      end
      r.owner_valid = held;
      if (held) begin
        r.owner_task = holder;
        r.owner_priority = holder_prio;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result with no request pending: status %0d owner %0d", got.status,
                   got.owner_task);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.woken_valid !== want.woken_valid ||
          got.woken_task !== want.woken_task || got.owner_valid !== want.owner_valid ||
          got.owner_task !== want.owner_task || got.owner_priority !== want.owner_priority ||
          got.restored_valid !== want.restored_valid ||
          got.restored_priority !== want.restored_priority) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("mismatch at %0t: expected st %0d wk %0d/%0d own %0d/%0d/%0d rst %0d/%0d",
                   $realtime, want.status, want.woken_valid, want.woken_task,
                   want.owner_valid, want.owner_task, want.owner_priority,
                   want.restored_valid, want.restored_priority);
          $display("                  actual   st %0d wk %0d/%0d own %0d/%0d/%0d rst %0d/%0d",
                   got.status, got.woken_valid, got.woken_task, got.owner_valid,
                   got.owner_task, got.owner_priority, got.restored_valid,
                   got.restored_priority);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   in_kind;
  logic [ID_W-1:0]     in_task_id;
  logic [PRIO_W-1:0]   in_task_priority;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_woken_valid;
  logic [ID_W-1:0]     out_woken_task;
  logic                out_owner_valid;
  logic [ID_W-1:0]     out_owner_task;
  logic [PRIO_W-1:0]   out_owner_priority;
  logic                out_restored_valid;
  logic [PRIO_W-1:0]   out_restored_priority;

  lock_scoreboard sb;
  int             cycle_count = 0;
  int             lock_weight;
  int             roll;
  logic [KIND_W-1:0] rnd_kind;
  logic [ID_W-1:0]   rnd_id;

  priority_inheritance_lock #(
    .MAX_TASKS(MAX_WAITERS),
    .PRIORITY_BITS(PRIO_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_task_id(in_task_id),
    .in_task_priority(in_task_priority),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_woken_valid(out_woken_valid),
    .out_woken_task(out_woken_task),
    .out_owner_valid(out_owner_valid),
    .out_owner_task(out_owner_task),
    .out_owner_priority(out_owner_priority),
    .out_restored_valid(out_restored_valid),
    .out_restored_priority(out_restored_priority)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_status, out_woken_valid, out_woken_task, out_owner_valid,
                        out_owner_task, out_owner_priority, out_restored_valid,
                        out_restored_priority});
  end

  // holds the request until the block takes it, then records it
  task automatic send_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio);
    start <= 1'b1;
    in_kind <= kind;
    in_task_id <= id;
    in_task_priority <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(kind, id, prio);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // extremes and a few shared values so ties in the queue are common
  function automatic logic [PRIO_W-1:0] pick_priority();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(0, 9))
      0:       p = '0;
      1:       p = '1;
      2, 3, 4: p = PRIO_W'($urandom_range(0, 3) * 64 + 16);
      default: p = PRIO_W'($urandom_range(0, 255));
    endcase
    return p;
  endfunction

  initial begin
    sb = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_LOCK;
    in_task_id <= '0;
    in_task_priority <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // free lock: unlock and unknown kind are ignored
    send_request(KIND_UNLOCK, 4'd5, 8'd10);
    send_request(KIND_UNKNOWN, 4'd15, 8'hff);
    send_request(KIND_TRY, 4'd3, 8'd200);
    // trylock on a held lock, by the owner and by another task
    send_request(KIND_TRY, 4'd3, 8'd200);
    send_request(KIND_TRY, 4'd7, 8'd0);
    send_request(KIND_UNLOCK, 4'd9, 8'd0);
    // owner locks again and is queued like anyone else
    send_request(KIND_LOCK, 4'd3, 8'd200);
    idle_cycles(2);
    for (int i = 0; i < MAX_WAITERS - 2; i++)
      send_request(KIND_LOCK, ID_W'(i), (i == 0) ? 8'd0 : PRIO_W'($urandom_range(0, 255)));
    send_request(KIND_LOCK, 4'd15, 8'hff);
    // queue is full now
    send_request(KIND_LOCK, 4'd12, 8'd0);
    send_request(KIND_UNLOCK, 4'd3, 8'd0);
    send_request(KIND_UNLOCK, 4'd3, 8'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) lock_weight = $urandom_range(25, 65);
      roll = $urandom_range(0, 99);
      rnd_id = ID_W'($urandom_range(0, 15));
      if (roll < lock_weight) begin
        rnd_kind = KIND_LOCK;
      end else if (roll < lock_weight + 12) begin
        rnd_kind = KIND_TRY;
      end else if (roll < 97) begin
        rnd_kind = KIND_UNLOCK;
        if (sb.held && $urandom_range(0, 9) < 8) rnd_id = sb.holder;
      end else begin
        rnd_kind = KIND_UNKNOWN;
      end
      send_request(rnd_kind, rnd_id, pick_priority());
      // no gaps at all in the middle stretch
      if ((n < 400 || n >= 600) && $urandom_range(0, 99) < 8)
        idle_cycles($urandom_range(1, 4));
    end
    start <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/plim_pkg.sv
sv/plim_ctrl.sv
sv/plim_dpath.sv
sv/priority_inheritance_lock.sv
tb/tb_top.sv
